/* src/brf_pkg.sv */
// Shared constants for the received-byte ring FIFO: depth, pointer width,
// item action codes and the eight-byte reset sequence. No dependencies.
package brf_pkg;

  // Ring depth; one slot always stays empty
  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

  // Length of the magic reset sequence
  localparam int unsigned SEQ_LEN    = 8;

  // Item action codes
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_READ  = 1'b1
  } action_e;

  typedef logic [7:0] byte_t;
  typedef logic [PTR_W-1:0] ptr_t;

  // Reset sequence, oldest byte first
  localparam byte_t RST_SEQ [SEQ_LEN] = '{
    8'h03, 8'h14, 8'h00, 8'h02, 8'h81, 8'hC1, 8'h0D, 8'h0A
  };

endpackage

/* src/byte_ring_fifo_with_magic_reset.sv */
// Received-byte ring FIFO with magic reset sequence detection.
// Depends on brf_pkg for depth, action codes and the sequence bytes.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per item:
//   action_i selects a write of write_byte_i or a read of the oldest byte.
//   Output channel (out_valid_o / out_stall_i) returns one beat per item
//   with read_valid_o, read_data_o, write_dropped_o and reset_request_o.
//   A write, a dropped write and a read of an empty FIFO produce their
//   result beat in the cycle after acceptance, and the next item can follow
//   in the next cycle. A read of a stored byte goes through the synchronous
//   byte memory read and then the result register; the input stalls
//   during the memory read. Sustained rate: one write per cycle while the
//   receiver does not stall; no new item is taken during a memory read.
//   The byte memory has one write and one read port. The last seven bytes
//   behind the write pointer are mirrored in a small history register, so
//   the sequence check never needs the memory and the memory needs no
//   clearing pass after reset: reads only reach slots that were written.
//   Reset empties the FIFO and zeroes the history. While the receiver
//   stalls, the result beat holds and the input stalls too.
module byte_ring_fifo_with_magic_reset (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic         action_i,
  input  brf_pkg::byte_t write_byte_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic         read_valid_o,
  output brf_pkg::byte_t read_data_o,
  output logic         write_dropped_o,
  output logic         reset_request_o
);
  import brf_pkg::*;

  localparam int unsigned HIST_LEN = SEQ_LEN - 1;
  localparam ptr_t PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // Byte memory, one write and one registered read port
  byte_t byte_mem [FIFO_DEPTH];
  byte_t rd_data_q;

  ptr_t  wr_ptr_q, wr_ptr_d;
  ptr_t  rd_ptr_q, rd_ptr_d;
  ptr_t  wr_ptr_nxt, rd_ptr_nxt;
  byte_t hist_q [HIST_LEN];   // index 0 is the newest byte behind wr_ptr_q
  logic  pend_q;              // memory read in flight

  logic  out_valid_q, read_valid_q, dropped_q, rst_req_q;
  byte_t read_data_q;

  logic  accept, out_free, empty, full, seq_hit;
  logic  do_write, do_read;

  // Wrap pointers at any depth
  assign wr_ptr_nxt = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
  assign empty      = (rd_ptr_q == wr_ptr_q);
  assign full       = (wr_ptr_nxt == rd_ptr_q);

  // Accept when no read is in flight and the result slot frees up
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = pend_q || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign do_write   = accept && (action_e'(action_i) == ACT_WRITE) && !full;
  assign do_read    = accept && (action_e'(action_i) == ACT_READ) && !empty;

  // Compare history plus incoming byte against the sequence
  always_comb begin
    seq_hit = (write_byte_i == RST_SEQ[SEQ_LEN-1]);
    for (int k = 0; k < HIST_LEN; k++) begin
      if (hist_q[k] != RST_SEQ[HIST_LEN-1-k]) seq_hit = 1'b0;
    end
  end

  // Advance pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_write && !seq_hit) wr_ptr_d = wr_ptr_nxt;
    if (do_read) rd_ptr_d = rd_ptr_nxt;
  end

  // Byte memory write and read
  always_ff @(posedge clk_i) begin
    if (do_write) byte_mem[wr_ptr_q] <= write_byte_i;
    if (do_read) rd_data_q <= byte_mem[rd_ptr_q];
  end

  // Pointers, history and pending flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      pend_q   <= 1'b0;
      for (int k = 0; k < HIST_LEN; k++) hist_q[k] <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      pend_q   <= do_read;
      // Shift in the stored byte when the write pointer moves past it
      if (do_write && !seq_hit) begin
        hist_q[0] <= write_byte_i;
        for (int k = 1; k < HIST_LEN; k++) hist_q[k] <= hist_q[k-1];
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      read_valid_q <= 1'b0;
      read_data_q  <= '0;
      dropped_q    <= 1'b0;
      rst_req_q    <= 1'b0;
    end else if (pend_q) begin
      // Finish a read of a stored byte
      out_valid_q  <= 1'b1;
      read_valid_q <= 1'b1;
      read_data_q  <= rd_data_q;
      dropped_q    <= 1'b0;
      rst_req_q    <= 1'b0;
    end else if (accept && !do_read) begin
      // Write, dropped write or empty read
      out_valid_q  <= 1'b1;
      read_valid_q <= 1'b0;
      read_data_q  <= '0;
      dropped_q    <= (action_e'(action_i) == ACT_WRITE) && full;
      rst_req_q    <= do_write && seq_hit;
    end else if (out_free) begin
      out_valid_q  <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_valid_o    = read_valid_q;
  assign read_data_o     = read_data_q;
  assign write_dropped_o = dropped_q;
  assign reset_request_o = rst_req_q;

  // A memory read in flight never meets a pending result beat
  a_pend_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_valid_q)
    else $error("read in flight while result slot occupied");

  // A read of a stored byte returns its beat in the cycle after the memory read
  a_read_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_read |=> ##1 (out_valid_q && read_valid_q))
    else $error("stored-byte read did not produce a valid beat");

  // Result flags are exclusive
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones({read_valid_o, write_dropped_o, reset_request_o}) <= 1))
    else $error("more than one result flag set");

  // A reset request holds the write pointer
  a_rreq_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_write && seq_hit) |=> (wr_ptr_q == $past(wr_ptr_q)))
    else $error("write pointer moved on reset request");

  // Data is zero when no byte is returned
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !read_valid_o) |-> (read_data_o == '0))
    else $error("nonzero data without a read byte");

endmodule
